@@ hw/rtl/msbu_pkg.sv @@
// msbu_pkg: shared types, sizes and codes for the membership set block
// used by msbu_ctrl, msbu_dp, the top level and the checker; no dependencies
`timescale 1ns / 1ps

package msbu_pkg;

	// set capacity and derived widths
	localparam int MAX_MEMBERS = 64;
	localparam int IDX_W       = $clog2(MAX_MEMBERS);
	localparam int CNT_W       = $clog2(MAX_MEMBERS + 1);
	localparam int ID_W        = 16;
	localparam int VIEW_W      = 16;
	localparam int COUNT_W     = 7;

	// change actions
	localparam logic [1:0] ACT_DROP = 2'd0;
	localparam logic [1:0] ACT_ADD  = 2'd1;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_PRESENT   = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_UNDEFINED = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	// input request
	typedef struct packed {
		logic [1:0]      action_code;
		logic [ID_W-1:0] member_id;
		logic            last_change;
	} change_t;

	// output request
	typedef struct packed {
		logic [2:0]         status;
		logic [VIEW_W-1:0]  view_number;
		logic               member_valid;
		logic [ID_W-1:0]    member_out;
		logic [COUNT_W-1:0] member_count;
		logic               last_result;
	} result_t;

	// controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_DECIDE,
		S_FILL,
		S_BATCH_END,
		S_EMIT_EMPTY,
		S_SEL_START,
		S_SEL_SCAN,
		S_SEL_EMIT,
		S_EMIT_ERR,
		S_COPY
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic       load_item;
		logic       scan_start;
		logic       scan_run;
		logic       err_wr;
		logic [2:0] err_code;
		logic       append;
		logic       rd_last;
		logic       fill_hole;
		logic       view_inc;
		logic       commit_start;
		logic       push;
		logic       push_member;
		logic       commit_wr;
		logic       copy_start;
		logic       copy_run;
		logic       restore;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic [1:0] act;
		logic       last;
		logic       err_set;
		logic       hit;
		logic       full;
		logic       wcount_zero;
		logic       scan_done;
		logic       copy_done;
		logic       out_free;
		logic       k_last;
	} dp_sts_t;

endpackage

@@ hw/rtl/membership_set_batch_update.sv @@
// Membership set with batched add/drop changes and ordered commit.
// Each change runs a linear lookup scan over the single read port of the working
// memory; a drop adds a fill step that moves the last entry into the freed slot.
// Commit runs one full scan per member, emitting members in ascending order;
// a failed batch copies the committed memory back into the working memory.
// Reset (arst_n, async low) empties the set and clears view and error; no clearing pass.
`timescale 1ns / 1ps

module membership_set_batch_update (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              change_valid,
	output logic              change_stall,
	input  msbu_pkg::change_t change,
	output logic              result_valid,
	input  logic              result_stall,
	output msbu_pkg::result_t result
);

	msbu_pkg::dp_cmd_t cmd;
	msbu_pkg::dp_sts_t sts;

	// sequencer
	msbu_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.change_valid (change_valid),
		.change_stall (change_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	// storage and compare logic
	msbu_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.change       (change),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

@@ hw/rtl/msbu_dp.sv @@
// msbu_dp: datapath with working and committed member memories, scan unit,
// counters and the output register; depends on msbu_pkg
`timescale 1ns / 1ps

module msbu_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  msbu_pkg::change_t change,
	input  msbu_pkg::dp_cmd_t cmd,
	output msbu_pkg::dp_sts_t sts,
	output logic              result_valid,
	input  logic              result_stall,
	output msbu_pkg::result_t result
);

	// captured change
	logic [1:0]                 act_q;
	logic [msbu_pkg::ID_W-1:0]  id_q;
	logic                       last_q;

	// member memories
	logic [msbu_pkg::ID_W-1:0]  wmem [msbu_pkg::MAX_MEMBERS];
	logic [msbu_pkg::ID_W-1:0]  cmem [msbu_pkg::MAX_MEMBERS];

	// set state
	logic [msbu_pkg::CNT_W-1:0]  wcount_q;
	logic [msbu_pkg::CNT_W-1:0]  ccount_q;
	logic [2:0]                  err_q;
	logic [msbu_pkg::VIEW_W-1:0] view_q;

	// scan unit
	logic [msbu_pkg::CNT_W-1:0] sc_q;
	logic                       rv_s1;
	logic [msbu_pkg::IDX_W-1:0] ridx_s1;
	logic                       cv_s1;
	logic [msbu_pkg::IDX_W-1:0] cidx_s1;
	logic [msbu_pkg::ID_W-1:0]  wrd_q;
	logic [msbu_pkg::ID_W-1:0]  crd_q;
	logic                       hit_q;
	logic [msbu_pkg::IDX_W-1:0] pos_q;
	logic                       found_q;
	logic [msbu_pkg::ID_W-1:0]  best_q;
	logic [msbu_pkg::ID_W-1:0]  prev_q;
	logic                       first_q;
	logic [msbu_pkg::CNT_W-1:0] k_q;

	// output register
	logic              out_valid_q;
	msbu_pkg::result_t out_q;

	logic                       w_issue;
	logic                       c_issue;
	logic                       w_ren;
	logic [msbu_pkg::CNT_W-1:0] wlast;
	logic [msbu_pkg::IDX_W-1:0] w_raddr;
	logic                       w_we;
	logic [msbu_pkg::IDX_W-1:0] w_waddr;
	logic [msbu_pkg::ID_W-1:0]  w_wdata;
	logic                       cand;
	logic                       out_free;
	msbu_pkg::result_t          out_d;

	// read issue and address selection
	assign w_issue = cmd.scan_run && (sc_q < wcount_q);
	assign c_issue = cmd.copy_run && (sc_q < ccount_q);
	assign wlast   = wcount_q - msbu_pkg::CNT_W'(1);
	assign w_ren   = w_issue || cmd.rd_last;
	assign w_raddr = cmd.rd_last ? wlast[msbu_pkg::IDX_W-1:0] : sc_q[msbu_pkg::IDX_W-1:0];

	// working memory write selection
	always_comb begin
		w_we    = cmd.append || cmd.fill_hole || cv_s1;
		w_waddr = cidx_s1;
		w_wdata = crd_q;
		if (cmd.append) begin
			w_waddr = wcount_q[msbu_pkg::IDX_W-1:0];
			w_wdata = id_q;
		end else if (cmd.fill_hole) begin
			w_waddr = pos_q;
			w_wdata = wrd_q;
		end
	end

	// smallest entry above the previous one
	assign cand = (first_q || (wrd_q > prev_q)) && (!found_q || (wrd_q < best_q));

	// memories
	always_ff @(posedge clk) begin
		if (w_ren) begin
			wrd_q <= wmem[w_raddr];
		end
		if (w_we) begin
			wmem[w_waddr] <= w_wdata;
		end
		if (c_issue) begin
			crd_q <= cmem[sc_q[msbu_pkg::IDX_W-1:0]];
		end
		if (cmd.commit_wr) begin
			cmem[k_q[msbu_pkg::IDX_W-1:0]] <= best_q;
		end
	end

	// captured change and scan payload
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			act_q  <= change.action_code;
			id_q   <= change.member_id;
			last_q <= change.last_change;
		end
		ridx_s1 <= sc_q[msbu_pkg::IDX_W-1:0];
		cidx_s1 <= sc_q[msbu_pkg::IDX_W-1:0];
		if (rv_s1 && (wrd_q == id_q)) begin
			pos_q <= ridx_s1;
		end
		if (rv_s1 && cand) begin
			best_q <= wrd_q;
		end
		if (cmd.commit_wr) begin
			prev_q <= best_q;
		end
	end

	// control state of the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcount_q <= '0;
			ccount_q <= '0;
			err_q    <= msbu_pkg::ST_OK;
			view_q   <= '0;
			sc_q     <= '0;
			rv_s1    <= 1'b0;
			cv_s1    <= 1'b0;
			hit_q    <= 1'b0;
			found_q  <= 1'b0;
			first_q  <= 1'b1;
			k_q      <= '0;
		end else begin
			rv_s1 <= w_issue;
			cv_s1 <= c_issue;
			if (cmd.scan_start || cmd.copy_start) begin
				sc_q <= '0;
			end else if (w_issue || c_issue) begin
				sc_q <= sc_q + msbu_pkg::CNT_W'(1);
			end
			if (cmd.scan_start) begin
				hit_q   <= 1'b0;
				found_q <= 1'b0;
			end else if (rv_s1) begin
				if (wrd_q == id_q) begin
					hit_q <= 1'b1;
				end
				if (cand) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.append) begin
				wcount_q <= wcount_q + msbu_pkg::CNT_W'(1);
			end else if (cmd.fill_hole) begin
				wcount_q <= wlast;
			end else if (cmd.restore) begin
				wcount_q <= ccount_q;
			end
			if (cmd.err_wr) begin
				err_q <= cmd.err_code;
			end else if (cmd.restore) begin
				err_q <= msbu_pkg::ST_OK;
			end
			if (cmd.view_inc) begin
				view_q <= view_q + msbu_pkg::VIEW_W'(1);
			end
			if (cmd.commit_start) begin
				ccount_q <= wcount_q;
				k_q      <= '0;
				first_q  <= 1'b1;
			end else if (cmd.commit_wr) begin
				k_q     <= k_q + msbu_pkg::CNT_W'(1);
				first_q <= 1'b0;
			end
		end
	end

	// result payload
	always_comb begin
		out_d.status       = err_q;
		out_d.view_number  = view_q;
		out_d.member_valid = cmd.push_member;
		out_d.member_out   = cmd.push_member ? best_q : '0;
		out_d.member_count = msbu_pkg::COUNT_W'(ccount_q);
		out_d.last_result  = cmd.push_member ? sts.k_last : 1'b1;
	end

	// output register
	assign out_free = !out_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_q <= out_d;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// status to the controller
	always_comb begin
		sts.act         = act_q;
		sts.last        = last_q;
		sts.err_set     = (err_q != msbu_pkg::ST_OK);
		sts.hit         = hit_q;
		sts.full        = (wcount_q >= msbu_pkg::CNT_W'(msbu_pkg::MAX_MEMBERS));
		sts.wcount_zero = (wcount_q == '0);
		sts.scan_done   = (sc_q >= wcount_q) && !rv_s1;
		sts.copy_done   = (sc_q >= ccount_q) && !cv_s1;
		sts.out_free    = out_free;
		sts.k_last      = ((k_q + msbu_pkg::CNT_W'(1)) == ccount_q);
	end

endmodule

@@ hw/rtl/msbu_ctrl.sv @@
// msbu_ctrl: state machine that sequences lookup, update, commit and rollback
// depends on msbu_pkg; drives msbu_dp through command and status structs
`timescale 1ns / 1ps

module msbu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              change_valid,
	output logic              change_stall,
	input  msbu_pkg::dp_sts_t sts,
	output msbu_pkg::dp_cmd_t cmd
);

	msbu_pkg::state_t state_q;
	msbu_pkg::state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msbu_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.err_code = msbu_pkg::ST_OK;
		change_stall = 1'b1;
		unique case (state_q)
			msbu_pkg::S_IDLE: begin
				change_stall = 1'b0;
				if (change_valid) begin
					cmd.load_item = 1'b1;
					state_d       = msbu_pkg::S_CHECK;
				end
			end
			// skip after an error, flag undefined actions, else look up the id
			msbu_pkg::S_CHECK: begin
				if (sts.err_set) begin
					state_d = msbu_pkg::S_BATCH_END;
				end else if (sts.act != msbu_pkg::ACT_DROP && sts.act != msbu_pkg::ACT_ADD) begin
					cmd.err_wr   = 1'b1;
					cmd.err_code = msbu_pkg::ST_UNDEFINED;
					state_d      = msbu_pkg::S_BATCH_END;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = msbu_pkg::S_SCAN;
				end
			end
			msbu_pkg::S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_done) begin
					state_d = msbu_pkg::S_DECIDE;
				end
			end
			// apply the change to the working set
			msbu_pkg::S_DECIDE: begin
				state_d = msbu_pkg::S_BATCH_END;
				if (sts.act == msbu_pkg::ACT_ADD) begin
					if (sts.hit) begin
						cmd.err_wr   = 1'b1;
						cmd.err_code = msbu_pkg::ST_PRESENT;
					end else if (sts.full) begin
						cmd.err_wr   = 1'b1;
						cmd.err_code = msbu_pkg::ST_FULL;
					end else begin
						cmd.append = 1'b1;
					end
				end else if (!sts.hit) begin
					cmd.err_wr   = 1'b1;
					cmd.err_code = msbu_pkg::ST_NOT_FOUND;
				end else begin
					cmd.rd_last = 1'b1;
					state_d     = msbu_pkg::S_FILL;
				end
			end
			msbu_pkg::S_FILL: begin
				cmd.fill_hole = 1'b1;
				state_d       = msbu_pkg::S_BATCH_END;
			end
			// close the batch
			msbu_pkg::S_BATCH_END: begin
				if (!sts.last) begin
					state_d = msbu_pkg::S_IDLE;
				end else begin
					cmd.view_inc = 1'b1;
					if (sts.err_set) begin
						state_d = msbu_pkg::S_EMIT_ERR;
					end else begin
						cmd.commit_start = 1'b1;
						state_d = sts.wcount_zero ? msbu_pkg::S_EMIT_EMPTY : msbu_pkg::S_SEL_START;
					end
				end
			end
			msbu_pkg::S_EMIT_EMPTY: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					state_d  = msbu_pkg::S_IDLE;
				end
			end
			// ordered commit: one full scan per member
			msbu_pkg::S_SEL_START: begin
				cmd.scan_start = 1'b1;
				state_d        = msbu_pkg::S_SEL_SCAN;
			end
			msbu_pkg::S_SEL_SCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_done) begin
					state_d = msbu_pkg::S_SEL_EMIT;
				end
			end
			msbu_pkg::S_SEL_EMIT: begin
				if (sts.out_free) begin
					cmd.push        = 1'b1;
					cmd.push_member = 1'b1;
					cmd.commit_wr   = 1'b1;
					state_d = sts.k_last ? msbu_pkg::S_IDLE : msbu_pkg::S_SEL_START;
				end
			end
			// failed batch: report, then restore working set from committed
			msbu_pkg::S_EMIT_ERR: begin
				if (sts.out_free) begin
					cmd.push       = 1'b1;
					cmd.copy_start = 1'b1;
					state_d        = msbu_pkg::S_COPY;
				end
			end
			msbu_pkg::S_COPY: begin
				cmd.copy_run = 1'b1;
				if (sts.copy_done) begin
					cmd.restore = 1'b1;
					state_d     = msbu_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = msbu_pkg::S_IDLE;
			end
		endcase
	end

endmodule

@@ hw/rtl/msbu_checker.sv @@
// msbu_checker: port-level assertions for membership_set_batch_update
// depends on msbu_pkg; bound to the top level below
`timescale 1ns / 1ps

module msbu_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              change_valid,
	input logic              change_stall,
	input msbu_pkg::change_t change,
	input logic              result_valid,
	input logic              result_stall,
	input msbu_pkg::result_t result
);

	// a stalled result request holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// only member results may be non-final
	a_nonmember_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.member_valid |-> result.last_result && result.member_out == '0)
		else $error("non-member result not final");

	// a good result without a member reports an empty set
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == msbu_pkg::ST_OK && !result.member_valid
		|-> result.member_count == '0)
		else $error("empty commit with nonzero count");

	// changes wait while a batch is still streaming
	a_no_change_midstream: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_result |-> change_stall)
		else $error("change taken during member stream");

endmodule

bind membership_set_batch_update msbu_checker u_msbu_checker (.*);

@@ tb/membership_checker.sv @@
// membership_checker: watches both request channels of the membership set block,
// predicts every result request and compares it field by field
// depends on msbu_pkg for the request structs, sizes and status codes
`timescale 1ns / 1ps

module membership_checker
	import msbu_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    change_valid,
	input  logic    change_stall,
	input  change_t change,
	input  logic    result_valid,
	input  logic    result_stall,
	input  result_t result,
	output int      mismatches,
	output int      results_due
);

	// predicted block state: committed set, working copy, batch error, view
	logic [ID_W-1:0]    sealed_ids [MAX_MEMBERS];
	logic [COUNT_W-1:0] sealed_count;
	logic [ID_W-1:0]    draft_ids [MAX_MEMBERS];
	logic [COUNT_W-1:0] draft_count;
	logic [2:0]         batch_status;
	logic [VIEW_W-1:0]  view_no;
	result_t            pending_views [$];

	// slot of an id in the working copy, -1 when absent
	function automatic int draft_slot(logic [ID_W-1:0] id);
		for (int i = 0; i < draft_count; i++)
			if (draft_ids[i] == id) return i;
		return -1;
	endfunction

	// apply one change to the working copy and give its status
	function automatic logic [2:0] edit_draft(logic [1:0] act, logic [ID_W-1:0] id);
		int slot;
		slot = draft_slot(id);
		if (act == ACT_ADD) begin
			if (slot >= 0) return ST_PRESENT;
			if (draft_count >= MAX_MEMBERS) return ST_FULL;
			draft_ids[draft_count] = id;
			draft_count++;
			return ST_OK;
		end
		if (act == ACT_DROP) begin
			if (slot < 0) return ST_NOT_FOUND;
			// the last entry fills the freed slot
			draft_count--;
			draft_ids[slot] = draft_ids[draft_count];
			return ST_OK;
		end
		return ST_UNDEFINED;
	endfunction

	// predict the results of one accepted change request
	task automatic advance_view(change_t c);
		result_t         r;
		logic [ID_W-1:0] v;
		int              j;
		if (batch_status == ST_OK)
			batch_status = edit_draft(c.action_code, c.member_id);
		if (c.last_change) begin
			view_no++;
			r = '0;
			r.view_number = view_no;
			if (batch_status != ST_OK) begin
				// failed batch: one error result, working copy rolls back
				r.status       = batch_status;
				r.member_count = sealed_count;
				r.last_result  = 1'b1;
				pending_views.push_back(r);
				draft_ids   = sealed_ids;
				draft_count = sealed_count;
			end else begin
				// good batch: sort ascending and commit
				for (int i = 1; i < draft_count; i++) begin
					v = draft_ids[i];
					j = i;
					while (j > 0 && draft_ids[j-1] > v) begin
						draft_ids[j] = draft_ids[j-1];
						j--;
					end
					draft_ids[j] = v;
				end
				sealed_ids   = draft_ids;
				sealed_count = draft_count;
				r.status       = ST_OK;
				r.member_count = sealed_count;
				if (sealed_count == 0) begin
					r.last_result = 1'b1;
					pending_views.push_back(r);
				end
				for (int i = 0; i < sealed_count; i++) begin
					r.member_valid = 1'b1;
					r.member_out   = sealed_ids[i];
					r.last_result  = (i == sealed_count - 1);
					pending_views.push_back(r);
				end
			end
			batch_status = ST_OK;
		end
	endtask

	// compare one accepted result request with the oldest prediction
	task automatic check_view(result_t got);
		result_t want;
		if (pending_views.size() == 0) begin
			$error("unexpected result: status %0d view %0d member %0h",
				got.status, got.view_number, got.member_out);
			mismatches++;
			return;
		end
		want = pending_views.pop_front();
		if (got.status !== want.status) begin
			$error("status: expected %0d, actual %0d", want.status, got.status);
			mismatches++;
		end
		if (got.view_number !== want.view_number) begin
			$error("view_number: expected %0d, actual %0d", want.view_number, got.view_number);
			mismatches++;
		end
		if (got.member_valid !== want.member_valid) begin
			$error("member_valid: expected %0b, actual %0b", want.member_valid, got.member_valid);
			mismatches++;
		end
		if (got.member_out !== want.member_out) begin
			$error("member_out: expected %0h, actual %0h", want.member_out, got.member_out);
			mismatches++;
		end
		if (got.member_count !== want.member_count) begin
			$error("member_count: expected %0d, actual %0d", want.member_count, got.member_count);
			mismatches++;
		end
		if (got.last_result !== want.last_result) begin
			$error("last_result: expected %0b, actual %0b", want.last_result, got.last_result);
			mismatches++;
		end
	endtask

	// sample both channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sealed_count = '0;
			draft_count  = '0;
			batch_status = ST_OK;
			view_no      = '0;
			pending_views.delete();
			mismatches   = 0;
			results_due  = 0;
		end else begin
			if (result_valid && !result_stall)
				check_view(result);
			if (change_valid && !change_stall)
				advance_view(change);
			results_due = pending_views.size();
		end
	end

endmodule

@@ tb/testbench.sv @@
// testbench: drives add/drop change requests into membership_set_batch_update,
// stalls its result channel at random and gives the verdict; checking is in membership_checker
// depends on msbu_pkg, membership_set_batch_update and membership_checker
`timescale 1ns / 1ps

module testbench;
	import msbu_pkg::*;

	localparam logic [1:0] ACT_SPARE_LO = 2'd2;
	localparam logic [1:0] ACT_SPARE_HI = 2'd3;
	localparam int RANDOM_CHANGES = 320;
	localparam int IDLE_PCT       = 14;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 200;

	logic    clk;
	logic    arst_n;
	logic    change_valid;
	logic    change_stall;
	change_t change;
	logic    result_valid;
	logic    result_stall;
	result_t result;
	int      mismatches;
	int      results_due;
	int      changes_sent;
	int      quiet_cycles;

	// stimulus-side view of the set, used only to pick sensible ids
	logic [ID_W-1:0] roster_draft [$];
	logic [ID_W-1:0] roster_sealed [$];
	bit              roster_broken;

	membership_set_batch_update DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.change_valid (change_valid),
		.change_stall (change_stall),
		.change       (change),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	membership_checker view_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.change_valid (change_valid),
		.change_stall (change_stall),
		.change       (change),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.mismatches   (mismatches),
		.results_due  (results_due)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// result back-pressure, with a long stall-free stretch
	always @(negedge clk) begin
		if (changes_sent >= 260 && changes_sent < 340)
			result_stall <= 1'b0;
		else
			result_stall <= ($urandom_range(0, 99) < IDLE_PCT);
	end

	// watchdog on cycles with no accepted request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((change_valid && !change_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic int roster_slot(logic [ID_W-1:0] id);
		foreach (roster_draft[i])
			if (roster_draft[i] == id) return i;
		return -1;
	endfunction

	function automatic logic [ID_W-1:0] fresh_id();
		logic [ID_W-1:0] id;
		do id = ID_W'($urandom_range(0, 65535)); while (roster_slot(id) >= 0);
		return id;
	endfunction

	function automatic logic [ID_W-1:0] held_id();
		return roster_draft[$urandom_range(0, roster_draft.size() - 1)];
	endfunction

	// follow a change in the stimulus-side view
	function automatic void track_change(logic [1:0] act, logic [ID_W-1:0] id, logic last);
		int slot;
		slot = roster_slot(id);
		if (!roster_broken) begin
			if (act == ACT_ADD) begin
				if (slot >= 0 || roster_draft.size() >= MAX_MEMBERS) roster_broken = 1'b1;
				else roster_draft.push_back(id);
			end else if (act == ACT_DROP) begin
				if (slot < 0) roster_broken = 1'b1;
				else roster_draft.delete(slot);
			end else begin
				roster_broken = 1'b1;
			end
		end
		if (last) begin
			if (roster_broken) roster_draft = roster_sealed;
			else roster_sealed = roster_draft;
			roster_broken = 1'b0;
		end
	endfunction

	// one change request, with random gaps before it
	task automatic send_change(input logic [1:0] act, input logic [ID_W-1:0] id,
		input logic last);
		@(negedge clk);
		while (!(changes_sent >= 120 && changes_sent < 200) &&
			$urandom_range(0, 99) < IDLE_PCT) begin
			change_valid <= 1'b0;
			@(negedge clk);
		end
		change_valid <= 1'b1;
		change       <= '{action_code: act, member_id: id, last_change: last};
		track_change(act, id, last);
		do @(posedge clk); while (change_stall);
		changes_sent++;
	endtask

	// a change that is legal for the current working copy
	task automatic send_sound_change(input logic last);
		int add_pct;
		add_pct = roster_draft.size() < 16 ? 70 : (roster_draft.size() > 48 ? 30 : 55);
		if (roster_draft.size() == 0 ||
			(roster_draft.size() < MAX_MEMBERS && $urandom_range(0, 99) < add_pct))
			send_change(ACT_ADD, fresh_id(), last);
		else
			send_change(ACT_DROP, held_id(), last);
	endtask

	// a change that makes the batch fail
	task automatic send_faulty_change(input logic last);
		case ($urandom_range(0, 3))
			0: begin
				if (roster_draft.size() > 0) send_change(ACT_ADD, held_id(), last);
				else send_change(ACT_DROP, fresh_id(), last);
			end
			1: begin
				send_change(ACT_DROP, fresh_id(), last);
			end
			2: begin
				send_change($urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO,
					ID_W'($urandom_range(0, 65535)), last);
			end
			default: begin
				if (roster_draft.size() == MAX_MEMBERS) send_change(ACT_ADD, fresh_id(), last);
				else send_change(ACT_DROP, fresh_id(), last);
			end
		endcase
	endtask

	// any action, ids mostly from a small range so that hits happen
	task automatic send_noise_change(input logic last);
		logic [1:0]      act;
		logic [ID_W-1:0] id;
		act = 2'($urandom_range(0, 3));
		id  = $urandom_range(0, 1) ? ID_W'($urandom_range(0, 15)) :
			ID_W'($urandom_range(0, 65535));
		send_change(act, id, last);
	endtask

	// grow the set to capacity, then push past it
	task automatic fill_roster();
		int need;
		need = MAX_MEMBERS - roster_draft.size();
		for (int k = 0; k < need; k++)
			send_change(ACT_ADD, fresh_id(), k == need - 1);
		send_change(ACT_ADD, fresh_id(), 1'b1);
		send_change(ACT_DROP, held_id(), 1'b0);
		send_change(ACT_ADD, fresh_id(), 1'b1);
		send_change(ACT_ADD, fresh_id(), 1'b0);
		send_change(ACT_DROP, held_id(), 1'b1);
	endtask

	initial begin
		int  random_sent;
		int  roll;
		int  span;
		int  cut;
		bit  filled;
		logic last;

		arst_n        = 1'b0;
		change_valid  = 1'b0;
		change        = '0;
		changes_sent  = 0;
		roster_broken = 1'b0;
		filled        = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drop from the empty set
		send_change(ACT_DROP, 16'd5, 1'b1);
		// extreme ids, committed in ascending order
		send_change(ACT_ADD, 16'h0000, 1'b0);
		send_change(ACT_ADD, 16'hFFFF, 1'b0);
		send_change(ACT_ADD, 16'h8000, 1'b1);
		// add of a present id
		send_change(ACT_ADD, 16'h0000, 1'b1);
		// both undefined actions, later change ignored
		send_change(ACT_SPARE_LO, 16'd7, 1'b1);
		send_change(ACT_SPARE_HI, 16'h1234, 1'b0);
		send_change(ACT_ADD, 16'd9, 1'b1);
		// drop of the entry in the last slot, then two adds in the same batch
		send_change(ACT_DROP, 16'hFFFF, 1'b0);
		send_change(ACT_ADD, 16'hFFFF, 1'b0);
		send_change(ACT_ADD, 16'h7FFF, 1'b1);
		// good batch that leaves the set empty
		send_change(ACT_ADD, 16'd40, 1'b0);
		send_change(ACT_DROP, 16'd40, 1'b0);
		send_change(ACT_DROP, 16'h0000, 1'b0);
		send_change(ACT_DROP, 16'hFFFF, 1'b0);
		send_change(ACT_DROP, 16'h8000, 1'b0);
		send_change(ACT_DROP, 16'h7FFF, 1'b1);
		// error in mid batch, then more changes
		send_change(ACT_ADD, 16'd100, 1'b0);
		send_change(ACT_DROP, 16'd200, 1'b0);
		send_change(ACT_ADD, 16'd300, 1'b1);
		// alternating bit patterns
		send_change(ACT_ADD, 16'h5555, 1'b0);
		send_change(ACT_ADD, 16'hAAAA, 1'b1);

		// random batches: mostly legal, some failing, some noise
		random_sent = 0;
		while (random_sent < RANDOM_CHANGES) begin
			if (!filled && random_sent >= 200) begin
				fill_roster();
				filled = 1'b1;
			end
			roll = $urandom_range(0, 99);
			span = $urandom_range(1, 8);
			cut  = $urandom_range(0, span - 1);
			for (int k = 0; k < span; k++) begin
				last = (k == span - 1);
				if (roll < 70) send_sound_change(last);
				else if (roll < 85 && k < cut) send_sound_change(last);
				else if (roll < 85 && k == cut) send_faulty_change(last);
				else send_noise_change(last);
			end
			random_sent += span;
		end

		@(negedge clk);
		change_valid <= 1'b0;
		wait (results_due == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
